// ----- rtl/mwh_pkg.sv -----
`timescale 1ns / 1ps

package mwh_pkg;

    // Mixing constant and shift amounts of the hash
    localparam logic [31:0] MURMUR_M    = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // How the back end treats one item
    typedef enum logic [1:0] {
        KIND_FULL     = 2'd0,   // four bytes, full word mix
        KIND_TAIL_MUL = 2'd1,   // one to three tail bytes, then h*M
        KIND_TAIL_NOP = 2'd2    // no bytes, hash unchanged
    } t_kind;

    // Classified item, as queued between front and back
    typedef struct packed {
        logic [31:0] word;        // raw key word
        logic [23:0] tail;        // masked tail bytes, zero for a full word
        logic [63:0] start_hash;  // seed ^ length, used when start is set
        logic        start;       // first item of a key
        logic        last;        // final item of a key
        t_kind       kind;
    } t_item;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,   // take next item, k = word*M mixed
        ST_K3L  = 3'd1,   // low half of k*M
        ST_K3H  = 3'd2,   // high half of k*M
        ST_HL   = 3'd3,   // low half of h*M
        ST_HH   = 3'd4,   // high half of h*M, xor k
        ST_FL   = 3'd5,   // h ^= h>>13, low half of h*M
        ST_FH   = 3'd6    // high half of h*M, h ^= h>>15, to output
    } t_back_state;

endpackage

// ----- rtl/murmur2_wide_hash_top.sv -----
`timescale 1ns / 1ps

// MurmurHash2 key hasher in 64-bit arithmetic.
// Input stream (s_axis): one little-endian key word per transfer. tdata holds
// key_word, byte_count and key_length; tlast marks the last item of a key.
// key_length is read only on the first item of a key (after reset or after
// a tlast transfer); the hash starts there as seed ^ length.
// Output stream (m_axis): one 64-bit hash per key, after its tlast item.
// Config channel: a transfer on i_cfg_valid writes the 64-bit seed; it is
// always ready; the user is to use it only between keys (not enforced here).
// Structure: items pass a small queue into a sequencer with one 32x32 constant
// multiplier that forms each 64-bit product as a low and a high half. A full
// word steps through IDLE, K3L, K3H, HL, HH, a 1-3 byte tail through IDLE, HL,
// HH, an empty item through IDLE only; a last item adds FL and FH, and FH loads
// the hash into the output register. A new item is taken only back in IDLE.
// A stalled m_axis holds the finished hash in the output register while the
// queue keeps taking items; the sequencer waits only when it has a second
// hash ready. Reset clears the seed to zero and starts a new key.
module murmur2_wide_hash_top
    import mwh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    // key items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // key_word[31:0], byte_count[34:32],
                                       // key_length[50:35], zero[55:51]
    input  logic        s_axis_tlast,
    // hashes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // hash_value[63:0]
);

    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_q_valid;

    assign o_cfg_ready = 1'b1;

    mwh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_key_word   (s_axis_tdata[31:0]),
        .i_byte_count (s_axis_tdata[34:32]),
        .i_last_item  (s_axis_tlast),
        .i_key_length (s_axis_tdata[50:35]),
        .i_queue_full (w_full),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    mwh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item)
    );

    mwh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_hash  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

endmodule

// ----- rtl/mwh_front.sv -----
`timescale 1ns / 1ps

module mwh_front
    import mwh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_valid,
    input  logic [63:0] i_cfg_data,
    // raw input item
    input  logic        i_valid,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_item,
    input  logic [15:0] i_key_length,
    input  logic        i_queue_full,
    output logic        o_ready,
    // classified item to queue
    output logic        o_push,
    output t_item       o_item
);

    logic [63:0] r_seed;
    logic        r_inside;
    logic        w_accept;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    // Key framing: the item after a last item starts a new key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
        end else if (w_accept) begin
            r_inside <= !i_last_item;
        end
    end

    // Classify: counts of four and above are full words, bytes past the count drop
    always_comb begin
        o_item            = '0;
        o_item.word       = i_key_word;
        o_item.start_hash = r_seed ^ {48'b0, i_key_length};
        o_item.start      = !r_inside;
        o_item.last       = i_last_item;
        if (i_byte_count[2]) begin
            o_item.kind = KIND_FULL;
            o_item.tail = '0;
        end else if (i_byte_count == 3'd0) begin
            o_item.kind = KIND_TAIL_NOP;
            o_item.tail = '0;
        end else begin
            o_item.kind        = KIND_TAIL_MUL;
            o_item.tail[7:0]   = i_key_word[7:0];
            o_item.tail[15:8]  = (i_byte_count >= 3'd2) ? i_key_word[15:8] : 8'd0;
            o_item.tail[23:16] = (i_byte_count == 3'd3) ? i_key_word[23:16] : 8'd0;
        end
    end

endmodule

// ----- rtl/mwh_queue.sv -----
`timescale 1ns / 1ps

module mwh_queue
    import mwh_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd];
    assign w_do_pop = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_empty_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1) && w_do_pop && !i_push) |=> !o_valid)
        else $error("queue not empty after last entry popped");

endmodule

// ----- rtl/mwh_back.sv -----
`timescale 1ns / 1ps

module mwh_back
    import mwh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // queue side
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    // result side
    output logic        o_valid,
    output logic [63:0] o_hash,
    input  logic        i_ready
);

    t_back_state r_state;
    t_back_state n_state;

    logic [63:0] r_h;
    logic [63:0] r_k;
    logic [63:0] r_p;
    logic        r_last;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic [31:0] w_mul_a;
    logic [63:0] w_prod;
    logic [63:0] w_k1;
    logic [63:0] w_fin_t;
    logic [63:0] w_sum;
    logic [63:0] w_fin;
    logic        w_load_out;

    // One shared 32x32 constant multiplier, one partial product a cycle
    assign w_prod  = {32'b0, w_mul_a} * {32'b0, MURMUR_M};
    assign w_k1    = w_prod ^ (w_prod >> MIX_SHIFT);
    assign w_fin_t = r_h ^ (r_h >> FIN_SHIFT_A);
    // 64-bit product: low partial plus high partial shifted up by 32
    assign w_sum   = {r_p[63:32] + w_prod[31:0], r_p[31:0]};
    assign w_fin   = w_sum ^ (w_sum >> FIN_SHIFT_B);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_item.kind)
                        KIND_FULL:     n_state = ST_K3L;
                        KIND_TAIL_MUL: n_state = ST_HL;
                        default:       n_state = i_item.last ? ST_FL : ST_IDLE;
                    endcase
                end
            end
            ST_K3L:  n_state = ST_K3H;
            ST_K3H:  n_state = ST_HL;
            ST_HL:   n_state = ST_HH;
            ST_HH:   n_state = r_last ? ST_FL : ST_IDLE;
            ST_FL:   n_state = ST_FH;
            ST_FH:   n_state = w_load_out ? ST_IDLE : ST_FH;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop, multiplier operand, result load
    always_comb begin
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        w_mul_a    = i_item.word;
        case (r_state)
            ST_IDLE: o_pop   = i_valid;
            ST_K3L:  w_mul_a = r_k[31:0];
            ST_K3H:  w_mul_a = r_k[63:32];
            ST_HL:   w_mul_a = r_h[31:0];
            ST_HH:   w_mul_a = r_h[63:32];
            ST_FL:   w_mul_a = w_fin_t[31:0];
            ST_FH: begin
                w_mul_a    = r_h[63:32];
                w_load_out = !r_out_valid || i_ready;
            end
            default: w_mul_a = i_item.word;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_h    <= (i_item.start ? i_item.start_hash : r_h)
                              ^ {40'b0, i_item.tail};
                    r_k    <= (i_item.kind == KIND_FULL) ? w_k1 : '0;
                    r_last <= i_item.last;
                end
            end
            ST_K3L: r_p <= w_prod;
            ST_K3H: r_k <= w_sum;
            ST_HL:  r_p <= w_prod;
            ST_HH:  r_h <= w_sum ^ r_k;
            ST_FL: begin
                r_h <= w_fin_t;
                r_p <= w_prod;
            end
            ST_FH: begin
                if (w_load_out) begin
                    r_out_data <= w_fin;
                end
            end
            default: r_p <= r_p;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hash  = r_out_data;

    a_fh_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FH && r_out_valid && !i_ready) |=> r_state == ST_FH)
        else $error("finalize left while output slot busy");

    a_hash_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HL) |=> (r_state == ST_HH))
        else $error("hash multiply high half skipped");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && i_valid))
        else $error("queue popped while busy");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mwh_pkg::*;

    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          SETTLE_CYCLES   = 32;
    localparam int          ITEMS_PER_PHASE = 230;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          GAP_PCT         = 30;
    localparam int          N_PHASES        = 6;
    localparam int          N_DIRECTED      = 20;
    localparam logic [63:0] HASH_MUL        = 64'(MURMUR_M);
    localparam int          MIX_SH          = MIX_SHIFT;
    localparam int          FIN_SH_A        = FIN_SHIFT_A;
    localparam int          FIN_SH_B        = FIN_SHIFT_B;

    // One row of the directed table; hash is used only when typed is set
    typedef struct packed {
        logic [31:0] key_word;
        logic [2:0]  byte_count;
        logic        last_item;
        logic [15:0] key_length;
        logic        typed;
        logic [63:0] hash;
    } t_stim_row;

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // empty key right after reset: seed 0, length 0 hashes to 0
        '{32'h0000_0000, 3'd0, 1'b1, 16'h0000, 1'b1, 64'h0},
        // empty item inside a key, bytes beyond count are don't-care
        '{32'hFFFF_FFFF, 3'd0, 1'b0, 16'h0000, 1'b0, 64'h0},
        '{32'hFFFF_FFFF, 3'd0, 1'b1, 16'h0000, 1'b1, 64'h0},
        // extremes of word and length
        '{32'hFFFF_FFFF, 3'd4, 1'b1, 16'hFFFF, 1'b0, 64'h0},
        '{32'h0000_0000, 3'd4, 1'b1, 16'h0004, 1'b0, 64'h0},
        // one, two and three tail bytes with garbage above the count
        '{32'hFFFF_FFFF, 3'd1, 1'b1, 16'h0001, 1'b0, 64'h0},
        '{32'hFFFF_FFFF, 3'd2, 1'b1, 16'h0002, 1'b0, 64'h0},
        '{32'hFFFF_FFFF, 3'd3, 1'b1, 16'h0003, 1'b0, 64'h0},
        // counts above four act as a full word
        '{32'h89AB_CDEF, 3'd5, 1'b1, 16'h0004, 1'b0, 64'h0},
        '{32'h0123_4567, 3'd6, 1'b0, 16'h0008, 1'b0, 64'h0},
        '{32'h7654_3210, 3'd7, 1'b1, 16'h0008, 1'b0, 64'h0},
        // short item that is not the last one
        '{32'hA5A5_A5A5, 3'd2, 1'b0, 16'h0006, 1'b0, 64'h0},
        '{32'h5A5A_5A5A, 3'd4, 1'b1, 16'h0006, 1'b0, 64'h0},
        // length field disagrees with the bytes sent
        '{32'hDEAD_BEEF, 3'd4, 1'b1, 16'd100,  1'b0, 64'h0},
        // multi-word key ending in a tail
        '{32'hCAFE_F00D, 3'd4, 1'b0, 16'd11,   1'b0, 64'h0},
        '{32'h0BAD_F00D, 3'd4, 1'b0, 16'h0000, 1'b0, 64'h0},
        '{32'h1234_5678, 3'd3, 1'b1, 16'h0000, 1'b0, 64'h0},
        '{32'h8000_0000, 3'd4, 1'b0, 16'h8000, 1'b0, 64'h0},
        '{32'h0000_0080, 3'd1, 1'b0, 16'h0000, 1'b0, 64'h0},
        '{32'h7FFF_FFFF, 3'd3, 1'b1, 16'h0000, 1'b0, 64'h0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    // Hash state mirror
    logic [63:0] seed_value = '0;
    logic [63:0] run_hash   = '0;
    bit          in_key     = 1'b0;

    logic [63:0] hash_q [$];
    logic [63:0] expected_hash;
    int          fail_count   = 0;
    int          stall_cycles = 0;
    bit          gaps_on      = 1'b1;
    int          hold_asks    = 0;
    int          hold_served  = 0;
    int          hold_left    = 0;

    murmur2_wide_hash_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Full word: k*M, k ^= k>>24, k*M, then h*M ^ k
    function automatic logic [63:0] mix_full_word(input logic [63:0] h, input logic [31:0] w);
        logic [63:0] k;
        k = {32'b0, w} * HASH_MUL;
        k = k ^ (k >> MIX_SH);
        k = k * HASH_MUL;
        return (h * HASH_MUL) ^ k;
    endfunction

    // 1..3 tail bytes XORed in place, then h*M; no bytes leaves h alone
    function automatic logic [63:0] mix_tail_bytes(input logic [63:0] h, input logic [31:0] w,
                                                   input logic [2:0] n);
        if (n >= 3'd3) h = h ^ {40'b0, w[23:16], 16'b0};
        if (n >= 3'd2) h = h ^ {48'b0, w[15:8], 8'b0};
        if (n >= 3'd1) begin
            h = h ^ {56'b0, w[7:0]};
            h = h * HASH_MUL;
        end
        return h;
    endfunction

    function automatic logic [63:0] finalize_hash(input logic [63:0] h);
        h = h ^ (h >> FIN_SH_A);
        h = h * HASH_MUL;
        return h ^ (h >> FIN_SH_B);
    endfunction

    // Advance the mirrored hash by one accepted item
    task automatic hash_step(input logic [31:0] key_word, input logic [2:0] byte_count,
                             input bit last_item, input logic [15:0] key_length,
                             output bit done, output logic [63:0] hash);
        logic [63:0] h;
        logic [2:0]  n;
        n = (byte_count > 3'd4) ? 3'd4 : byte_count;
        h = in_key ? run_hash : (seed_value ^ {48'b0, key_length});
        if (n == 3'd4)
            h = mix_full_word(h, key_word);
        else
            h = mix_tail_bytes(h, key_word, n);
        done = last_item;
        if (last_item) begin
            hash     = finalize_hash(h);
            run_hash = '0;
            in_key   = 1'b0;
        end else begin
            hash     = '0;
            run_hash = h;
            in_key   = 1'b1;
        end
    endtask

    // Offer one item after a random gap; queue its hash once transferred
    task automatic send_item(input logic [31:0] key_word, input logic [2:0] byte_count,
                             input bit last_item, input logic [15:0] key_length,
                             input bit typed, input logic [63:0] typed_hash);
        bit          done;
        logic [63:0] hash;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, key_length, byte_count, key_word};
        s_axis_tlast  <= last_item;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hash_step(key_word, byte_count, last_item, key_length, done, hash);
        if (done) hash_q.push_back(typed ? typed_hash : hash);
    endtask

    // Stop offering, drain all hashes, then let the sequencer settle
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [63:0] value);
        quiesce();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed_value = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed keys of random content, some stray items
    task automatic send_random_key(output int n_items);
        int          key_bytes;
        int          full_words;
        int          tail_bytes;
        logic [15:0] len_field;
        logic [2:0]  full_cnt;
        bit          end_on_word;
        n_items = 0;
        if ($urandom_range(99) < 8) begin
            send_item($urandom, 3'($urandom_range(7)), ($urandom_range(99) < 30),
                      16'($urandom), 1'b0, '0);
            n_items = 1;
        end else begin
            key_bytes = ($urandom_range(99) < 85) ? $urandom_range(24) : $urandom_range(64, 25);
            len_field = 16'(key_bytes);
            if ($urandom_range(99) < 10) len_field = 16'($urandom);
            if ($urandom_range(99) < 2)  len_field = 16'hFFFF;
            full_words  = key_bytes / 4;
            tail_bytes  = key_bytes % 4;
            end_on_word = (tail_bytes == 0) && (full_words > 0) && ($urandom_range(1) == 1);
            for (int i = 0; i < full_words; i++) begin
                full_cnt = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 5)) : 3'd4;
                send_item($urandom, full_cnt, end_on_word && (i == full_words - 1),
                          (i == 0) ? len_field : 16'($urandom), 1'b0, '0);
                n_items++;
            end
            if (!end_on_word) begin
                send_item($urandom, 3'(tail_bytes), 1'b1,
                          (full_words == 0) ? len_field : 16'($urandom), 1'b0, '0);
                n_items++;
            end
        end
    endtask

    // Hash receiver: random backpressure plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
        end
    end

    // Compare each hash transfer with the oldest outstanding one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hash_q.size() == 0) begin
                $error("hash_value: expected none, actual %h", m_axis_tdata);
                fail_count++;
            end else begin
                expected_hash = hash_q.pop_front();
                if (m_axis_tdata !== expected_hash) begin
                    $error("hash_value: expected %h, actual %h", expected_hash, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          phase_items;
        int          n;
        logic [63:0] seeds [N_PHASES];
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset seed
        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED[r].key_word, DIRECTED[r].byte_count, DIRECTED[r].last_item,
                      DIRECTED[r].key_length, DIRECTED[r].typed, DIRECTED[r].hash);

        seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h1, {$urandom, $urandom},
                  64'h8000_0000_0000_0000, 64'h0, {$urandom, $urandom}};

        // Random keys, one seed per phase
        for (int p = 0; p < N_PHASES; p++) begin
            load_seed(seeds[p]);
            gaps_on = (p != 1);
            if (p == 4) hold_asks++;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                send_random_key(n);
                phase_items += n;
            end
            // leave a key open so the next seed lands mid-key
            if (p == 2)
                send_item($urandom, 3'd4, 1'b0, 16'($urandom), 1'b0, '0);
        end

        quiesce();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mwh_pkg.sv
rtl/mwh_front.sv
rtl/mwh_queue.sv
rtl/mwh_back.sv
rtl/murmur2_wide_hash_top.sv
tb/sv/tb.sv
